[hdl/pies_pkg.sv]
// ----------------------------------------------------------------------------
// pies_pkg
// Shared types and constants for the periodic image element sorter.
// ----------------------------------------------------------------------------
package pies_pkg;

    localparam int PIES_MAX_ORBITALS = 4096;
    localparam int IMAGE_COUNT       = 9;
    localparam int IMG_W             = 4;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 32;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_LENGTH_Y  = 4'd0,
        CFG_CELL_LENGTH_Z  = 4'd1,
        CFG_ROW_BLOCK_SIZE = 4'd2,
        CFG_COL_BLOCK_SIZE = 4'd3,
        CFG_GRID_ROWS      = 4'd4,
        CFG_GRID_COLS      = 4'd5,
        CFG_MY_GRID_ROW    = 4'd6,
        CFG_MY_GRID_COL    = 4'd7
    } t_cfg_idx;

    // Shift applied along one axis for an image.
    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_PLUS  = 2'd1,
        SH_MINUS = 2'd2
    } t_shift;

    localparam t_shift IMG_SHIFT_Y [IMAGE_COUNT] = '{
        SH_NONE, SH_PLUS, SH_MINUS, SH_NONE, SH_NONE,
        SH_PLUS, SH_PLUS, SH_MINUS, SH_MINUS
    };
    localparam t_shift IMG_SHIFT_Z [IMAGE_COUNT] = '{
        SH_NONE, SH_NONE, SH_NONE, SH_PLUS, SH_MINUS,
        SH_PLUS, SH_MINUS, SH_PLUS, SH_MINUS
    };

    localparam int REM_W = 9;   // remainder of a 12-bit index by a 9-bit factor
    localparam int REM_BITS_PER_STAGE = 4;

endpackage

[hdl/pies_rem_step.sv]
// ----------------------------------------------------------------------------
// pies_rem_step
// A few steps of restoring division that keep only the remainder.
// ----------------------------------------------------------------------------
module pies_rem_step (
    input  logic [pies_pkg::REM_W-1:0]              i_rem,
    input  logic [pies_pkg::REM_BITS_PER_STAGE-1:0] i_bits,
    input  logic [pies_pkg::REM_W-1:0]              i_div,
    output logic [pies_pkg::REM_W-1:0]              o_rem
);
    import pies_pkg::*;

    always_comb begin
        logic [REM_W:0] w;
        logic [REM_W-1:0] r;
        r = i_rem;
        for (int i = REM_BITS_PER_STAGE - 1; i >= 0; i--) begin
            w = {r, i_bits[i]};
            if (w >= {1'b0, i_div}) begin
                w = w - {1'b0, i_div};
            end
            r = w[REM_W-1:0];
        end
        o_rem = r;
    end

endmodule

[hdl/periodic_image_element_sorter_core.sv]
// ----------------------------------------------------------------------------
// periodic_image_element_sorter_core
// Maps block-cyclic local indices to orbitals, looks up their coordinates and
// picks the nearest of nine periodic images for each matrix element.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the
// fourteen-stage pipeline and the two read ports of the coordinate table
// take a new item every cycle.
// Load items write the table at stage seven and give no result.
// Reset clears the stage valid bits and the configuration registers; the data registers and the table are not cleared.
module periodic_image_element_sorter_core #(
    parameter int MAX_ORBITALS = pies_pkg::PIES_MAX_ORBITALS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pies_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pies_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [11:0]                       i_orbital_slot,
    input  logic signed [31:0]                i_coord_y,
    input  logic signed [31:0]                i_coord_z,
    input  logic [11:0]                       i_local_row,
    input  logic [11:0]                       i_local_col,
    input  logic [11:0]                       i_row_base,
    input  logic [11:0]                       i_col_base,
    input  logic [12:0]                       i_local_rows,
    input  logic [23:0]                       i_block_start,
    input  logic [63:0]                       i_h_value,
    input  logic [63:0]                       i_s_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pies_pkg::IMG_W-1:0]        o_image_index,
    output logic [23:0]                       o_element_address,
    output logic [63:0]                       o_h_value_out,
    output logic [63:0]                       o_s_value_out
);
    import pies_pkg::*;

    localparam int AW = $clog2(MAX_ORBITALS);
    localparam int NS = 14;

    typedef struct packed {
        logic        op;
        logic [11:0] slot;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [11:0] lr;
        logic [11:0] lc;
        logic [11:0] rbase;
        logic [11:0] cbase;
        logic [12:0] rows;
        logic [23:0] start;
        logic [63:0] h;
        logic [63:0] s;
    } t_item;

    typedef struct packed {
        logic [23:0] addr;
        logic [63:0] h;
        logic [63:0] s;
    } t_meta;

    // Configuration registers.
    logic [30:0] r_cell_length_y, r_cell_length_z;
    logic [8:0]  r_row_block_size, r_col_block_size, r_grid_rows, r_grid_cols;
    logic [7:0]  r_my_grid_row, r_my_grid_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_length_y  <= '0;
            r_cell_length_z  <= '0;
            r_row_block_size <= 9'd1;
            r_col_block_size <= 9'd1;
            r_grid_rows      <= 9'd1;
            r_grid_cols      <= 9'd1;
            r_my_grid_row    <= '0;
            r_my_grid_col    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CELL_LENGTH_Y:  r_cell_length_y  <= i_cfg_data[30:0];
                CFG_CELL_LENGTH_Z:  r_cell_length_z  <= i_cfg_data[30:0];
                CFG_ROW_BLOCK_SIZE: r_row_block_size <= i_cfg_data[8:0];
                CFG_COL_BLOCK_SIZE: r_col_block_size <= i_cfg_data[8:0];
                CFG_GRID_ROWS:      r_grid_rows      <= i_cfg_data[8:0];
                CFG_GRID_COLS:      r_grid_cols      <= i_cfg_data[8:0];
                CFG_MY_GRID_ROW:    r_my_grid_row    <= i_cfg_data[7:0];
                CFG_MY_GRID_COL:    r_my_grid_col    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // A zero blocking factor behaves as one.
    logic [8:0] row_blk, col_blk;
    assign row_blk = (r_row_block_size == '0) ? 9'd1 : r_row_block_size;
    assign col_blk = (r_col_block_size == '0) ? 9'd1 : r_col_block_size;

    // Pipeline flow control: a stage moves when it is empty or the next one moves.
    logic [NS:1] r_v;
    logic [NS:1] en;
    logic        r_in_op6;

    always_comb begin
        en[NS] = !r_v[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    t_item r_in   [1:5];
    t_meta r_meta [6:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    if (k == 7) begin
                        r_v[k] <= r_v[6] && (r_in_op6 == OP_CLASSIFY);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_in[1] <= '{op: i_opcode, slot: i_orbital_slot, cy: i_coord_y,
                         cz: i_coord_z, lr: i_local_row, lc: i_local_col,
                         rbase: i_row_base, cbase: i_col_base, rows: i_local_rows,
                         start: i_block_start, h: i_h_value, s: i_s_value};
        end
        for (int k = 2; k <= 5; k++) begin
            if (en[k]) begin
                r_in[k] <= r_in[k-1];
            end
        end
    end

    // Stages 1 to 4: remainder of each local index by its blocking factor,
    // four quotient bits per stage.
    logic [REM_W-1:0] r_rr [2:5];
    logic [REM_W-1:0] r_rc [2:5];
    logic [REM_W-1:0] n_rr [2:4];
    logic [REM_W-1:0] n_rc [2:4];

    pies_rem_step u_rem_r0 (.i_rem('0), .i_bits(r_in[1].lr[11:8]),
                            .i_div(row_blk), .o_rem(n_rr[2]));
    pies_rem_step u_rem_c0 (.i_rem('0), .i_bits(r_in[1].lc[11:8]),
                            .i_div(col_blk), .o_rem(n_rc[2]));
    pies_rem_step u_rem_r1 (.i_rem(r_rr[2]), .i_bits(r_in[2].lr[7:4]),
                            .i_div(row_blk), .o_rem(n_rr[3]));
    pies_rem_step u_rem_c1 (.i_rem(r_rc[2]), .i_bits(r_in[2].lc[7:4]),
                            .i_div(col_blk), .o_rem(n_rc[3]));
    pies_rem_step u_rem_r2 (.i_rem(r_rr[3]), .i_bits(r_in[3].lr[3:0]),
                            .i_div(row_blk), .o_rem(n_rr[4]));
    pies_rem_step u_rem_c2 (.i_rem(r_rc[3]), .i_bits(r_in[3].lc[3:0]),
                            .i_div(col_blk), .o_rem(n_rc[4]));

    always_ff @(posedge i_clk) begin
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                r_rr[k] <= n_rr[k];
                r_rc[k] <= n_rc[k];
            end
        end
        if (en[5]) begin
            r_rr[5] <= r_rr[4];
            r_rc[5] <= r_rc[4];
        end
    end

    // Stage 4 to 5: products. Since quotient*factor equals local minus
    // remainder, no quotient is needed.
    logic [AW-1:0] r5_prr, r5_pcr, r5_pbr, r5_pbc;
    logic [23:0]   r5_ap;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_prr <= AW'(21'(r_in[4].lr - 12'(r_rr[4])) * 21'(r_grid_rows));
            r5_pcr <= AW'(21'(r_in[4].lc - 12'(r_rc[4])) * 21'(r_grid_cols));
            r5_pbr <= AW'(17'(r_my_grid_row) * 17'(row_blk));
            r5_pbc <= AW'(17'(r_my_grid_col) * 17'(col_blk));
            r5_ap  <= 24'(25'(r_in[4].lc) * 25'(r_in[4].rows));
        end
    end

    // Stage 5 to 6: table indices and element address.
    logic [AW-1:0] r6_ri, r6_ci, r6_slot;
    logic [63:0]   r6_wdata;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_ri    <= r5_prr + r5_pbr + AW'(r_rr[5]) + AW'(r_in[5].rbase);
            r6_ci    <= r5_pcr + r5_pbc + AW'(r_rc[5]) + AW'(r_in[5].cbase);
            r6_slot  <= AW'(r_in[5].slot);
            r6_wdata <= {r_in[5].cz, r_in[5].cy};
            r_in_op6 <= r_in[5].op;
            r_meta[6] <= '{addr: r_in[5].start + r5_ap + 24'(r_in[5].lr),
                           h: r_in[5].h, s: r_in[5].s};
        end
        for (int k = 7; k <= NS; k++) begin
            if (en[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // Stage 6 to 7: coordinate table, one write port and two read ports.
    logic [63:0] r_table [MAX_ORBITALS];
    logic [63:0] r7_er, r7_ec;

    always_ff @(posedge i_clk) begin
        if (en[7] && r_v[6] && (r_in_op6 == OP_LOAD)) begin
            r_table[r6_slot] <= r6_wdata;
        end
        if (en[7]) begin
            r7_er <= r_table[r6_ri];
            r7_ec <= r_table[r6_ci];
        end
    end

    // Stage 7 to 8: separations with each cell shift.
    logic signed [33:0] r8_y [3];
    logic signed [33:0] r8_z [3];
    logic signed [33:0] dy, dz, ly, lz;

    always_comb begin
        dy = 34'($signed(r7_er[31:0])) - 34'($signed(r7_ec[31:0]));
        dz = 34'($signed(r7_er[63:32])) - 34'($signed(r7_ec[63:32]));
        ly = $signed({3'b000, r_cell_length_y});
        lz = $signed({3'b000, r_cell_length_z});
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r8_y[SH_NONE]  <= dy;
            r8_y[SH_PLUS]  <= dy + ly;
            r8_y[SH_MINUS] <= dy - ly;
            r8_z[SH_NONE]  <= dz;
            r8_z[SH_PLUS]  <= dz + lz;
            r8_z[SH_MINUS] <= dz - lz;
        end
    end

    // Stage 8 to 9: magnitudes, y in entries 0 to 2 and z in 3 to 5.
    logic [32:0] r9_m [6];

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            for (int j = 0; j < 3; j++) begin
                r9_m[j]   <= r8_y[j][33] ? 33'(-r8_y[j]) : 33'(r8_y[j]);
                r9_m[j+3] <= r8_z[j][33] ? 33'(-r8_z[j]) : 33'(r8_z[j]);
            end
        end
    end

    // Stage 9 to 10: partial products of each square, upper 16 and lower 17 bits.
    logic [31:0] r10_aa [6];
    logic [32:0] r10_ab [6];
    logic [33:0] r10_bb [6];

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            for (int j = 0; j < 6; j++) begin
                r10_aa[j] <= 32'(r9_m[j][32:17]) * 32'(r9_m[j][32:17]);
                r10_ab[j] <= 33'(r9_m[j][32:17]) * 33'(r9_m[j][16:0]);
                r10_bb[j] <= 34'(r9_m[j][16:0]) * 34'(r9_m[j][16:0]);
            end
        end
    end

    // Stage 10 to 11: squares.
    logic [65:0] r11_sq [6];

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            for (int j = 0; j < 6; j++) begin
                r11_sq[j] <= (66'(r10_aa[j]) << 34) + (66'(r10_ab[j]) << 18)
                           + 66'(r10_bb[j]);
            end
        end
    end

    // Stage 11 to 12: squared distance of every image.
    logic [66:0] r12_d [IMAGE_COUNT];

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            for (int k = 0; k < IMAGE_COUNT; k++) begin
                r12_d[k] <= 67'(r11_sq[IMG_SHIFT_Y[k]]) + 67'(r11_sq[3 + IMG_SHIFT_Z[k]]);
            end
        end
    end

    // Stage 12 to 13: first minimum in each group of three; strict less
    // keeps the earlier image on a tie.
    logic [IMG_W-1:0] r13_gi [3];
    logic [66:0]      r13_gd [3];
    logic [IMG_W-1:0] n13_gi [3];
    logic [66:0]      n13_gd [3];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            n13_gi[g] = IMG_W'(3 * g);
            n13_gd[g] = r12_d[3 * g];
            for (int j = 1; j < 3; j++) begin
                if (r12_d[3 * g + j] < n13_gd[g]) begin
                    n13_gi[g] = IMG_W'(3 * g + j);
                    n13_gd[g] = r12_d[3 * g + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r13_gi <= n13_gi;
            r13_gd <= n13_gd;
        end
    end

    // Stage 13 to 14: first minimum over the groups, into the output register.
    logic [IMG_W-1:0] r14_img, n14_img;

    always_comb begin
        logic [66:0] bd;
        n14_img = r13_gi[0];
        bd      = r13_gd[0];
        for (int g = 1; g < 3; g++) begin
            if (r13_gd[g] < bd) begin
                n14_img = r13_gi[g];
                bd      = r13_gd[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r14_img <= n14_img;
        end
    end

    assign o_out_valid       = r_v[NS];
    assign o_image_index     = r14_img;
    assign o_element_address = r_meta[NS].addr;
    assign o_h_value_out     = r_meta[NS].h;
    assign o_s_value_out     = r_meta[NS].s;

endmodule

[hdl/pies_checker.sv]
// ----------------------------------------------------------------------------
// pies_checker
// Port-level checks on the periodic image element sorter, bound to its top.
// ----------------------------------------------------------------------------
module pies_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [pies_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pies_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [11:0]                       i_orbital_slot,
    input  logic signed [31:0]                i_coord_y,
    input  logic signed [31:0]                i_coord_z,
    input  logic [11:0]                       i_local_row,
    input  logic [11:0]                       i_local_col,
    input  logic [11:0]                       i_row_base,
    input  logic [11:0]                       i_col_base,
    input  logic [12:0]                       i_local_rows,
    input  logic [23:0]                       i_block_start,
    input  logic [63:0]                       i_h_value,
    input  logic [63:0]                       i_s_value,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [pies_pkg::IMG_W-1:0]        o_image_index,
    input  logic [23:0]                       o_element_address,
    input  logic [63:0]                       o_h_value_out,
    input  logic [63:0]                       o_s_value_out
);

    // With an empty output register every stage can move, so input is taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output register empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_image_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_image_index <= 4'd8))
        else $error("image index out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_image_index)
            && $stable(o_element_address) && $stable(o_h_value_out)))
        else $error("stalled result changed before transfer");

endmodule

bind periodic_image_element_sorter_core pies_checker u_pies_checker (.*);

[tb/periodic_image_element_sorter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_image_element_sorter_core_tb
// Drives coordinate loads and matrix element transfers into the sorter core
// under several grid and cell settings, with random stalls on both sides, and
// checks every result against a behavioural predictor of the nearest image.
// ----------------------------------------------------------------------------
module periodic_image_element_sorter_core_tb;
    import pies_pkg::*;

    typedef struct {
        t_opcode            op;
        logic [11:0]        slot;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [11:0]        lr;
        logic [11:0]        lc;
        logic [11:0]        rb;
        logic [11:0]        cb;
        logic [12:0]        lrows;
        logic [23:0]        bstart;
        logic [63:0]        h;
        logic [63:0]        s;
    } elem_item_t;

    typedef struct {
        logic [3:0]  img;
        logic [23:0] addr;
        logic [63:0] h;
        logic [63:0] s;
    } elem_result_t;

    class image_scoreboard;
        logic [63:0]  coord_mem [4096];
        logic [30:0]  len_y, len_z;
        logic [8:0]   rblk, cblk, grows, gcols;
        logic [7:0]   grow, gcol;
        elem_result_t awaited[$];
        int           fails;

        function new();
            len_y = '0; len_z = '0;
            rblk = 9'd1; cblk = 9'd1; grows = 9'd1; gcols = 9'd1;
            grow = '0; gcol = '0;
            fails = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [31:0] d);
            case (idx)
                CFG_CELL_LENGTH_Y:  len_y = d[30:0];
                CFG_CELL_LENGTH_Z:  len_z = d[30:0];
                CFG_ROW_BLOCK_SIZE: rblk  = d[8:0];
                CFG_COL_BLOCK_SIZE: cblk  = d[8:0];
                CFG_GRID_ROWS:      grows = d[8:0];
                CFG_GRID_COLS:      gcols = d[8:0];
                CFG_MY_GRID_ROW:    grow  = d[7:0];
                CFG_MY_GRID_COL:    gcol  = d[7:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] orbital(logic [11:0] loc, logic [8:0] blk,
                                      logic [8:0] grid, logic [7:0] pos,
                                      logic [11:0] base);
            longint unsigned b, g;
            b = (blk == 0) ? 1 : blk;
            g = (loc / b) * grid * b + pos * b + loc % b + base;
            return g[11:0];
        endfunction

        function logic [11:0] row_orbital(logic [11:0] lr, logic [11:0] rb);
            return orbital(lr, rblk, grows, grow, rb);
        endfunction

        function logic [11:0] col_orbital(logic [11:0] lc, logic [11:0] cb);
            return orbital(lc, cblk, gcols, gcol, cb);
        endfunction

        function logic [3:0] nearest_image(logic [63:0] er, logic [63:0] ec);
            longint      dy, dz, ly, lz, y, z;
            logic [71:0] my, mz, d, best_d;
            logic [3:0]  best;
            dy = longint'($signed(er[31:0])) - longint'($signed(ec[31:0]));
            dz = longint'($signed(er[63:32])) - longint'($signed(ec[63:32]));
            ly = longint'(len_y);
            lz = longint'(len_z);
            best = 0;
            best_d = '0;
            for (int k = 0; k < IMAGE_COUNT; k++) begin
                y = dy + (IMG_SHIFT_Y[k] == SH_PLUS ? ly :
                          IMG_SHIFT_Y[k] == SH_MINUS ? -ly : 0);
                z = dz + (IMG_SHIFT_Z[k] == SH_PLUS ? lz :
                          IMG_SHIFT_Z[k] == SH_MINUS ? -lz : 0);
                my = (y < 0) ? 72'(-y) : 72'(y);
                mz = (z < 0) ? 72'(-z) : 72'(z);
                d = my * my + mz * mz;
                if (k == 0 || d < best_d) begin
                    best = k[3:0];
                    best_d = d;
                end
            end
            return best;
        endfunction

        function void note_input(elem_item_t it);
            elem_result_t r;
            logic [23:0]  a;
            if (it.op == OP_LOAD) begin
                coord_mem[it.slot] = {it.z, it.y};
            end else begin
                r.img = nearest_image(coord_mem[row_orbital(it.lr, it.rb)],
                                      coord_mem[col_orbital(it.lc, it.cb)]);
                a = it.bstart + it.lc * it.lrows + it.lr;
                r.addr = a;
                r.h = it.h;
                r.s = it.s;
                awaited.push_back(r);
            end
        endfunction

        function void check_result(elem_result_t got);
            elem_result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing awaited: img %0d addr %h",
                         $time, got.img, got.addr);
                fails++;
                return;
            end
            e = awaited.pop_front();
            if (got.img !== e.img) begin
                $display("%0t: image_index expected %0d got %0d", $time, e.img, got.img);
                fails++;
            end
            if (got.addr !== e.addr) begin
                $display("%0t: element_address expected %h got %h",
                         $time, e.addr, got.addr);
                fails++;
            end
            if (got.h !== e.h) begin
                $display("%0t: h_value_out expected %h got %h", $time, e.h, got.h);
                fails++;
            end
            if (got.s !== e.s) begin
                $display("%0t: s_value_out expected %h got %h", $time, e.s, got.s);
                fails++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = 1'b0;
    logic [11:0] i_orbital_slot = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    logic [11:0] i_local_row = '0, i_local_col = '0;
    logic [11:0] i_row_base = '0, i_col_base = '0;
    logic [12:0] i_local_rows = '0;
    logic [23:0] i_block_start = '0;
    logic [63:0] i_h_value = '0, i_s_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_image_index;
    logic [23:0] o_element_address;
    logic [63:0] o_h_value_out, o_s_value_out;

    periodic_image_element_sorter_core dut (.*);

    image_scoreboard sb = new();
    bit   loaded [4096];
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    int   cycles = 0;
    int   sent = 0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold when requested.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && stall_left == 0) begin
                stall_left = 400;
                hold_req = 1'b0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            i_out_ready = (stall_left == 0) && i_rst_n;
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        elem_result_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.img = o_image_index;
            got.addr = o_element_address;
            got.h = o_h_value_out;
            got.s = o_s_value_out;
            sb.check_result(got);
        end
    end

    task automatic send(elem_item_t it);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_opcode = it.op;
        i_orbital_slot = it.slot;
        i_coord_y = it.y;
        i_coord_z = it.z;
        i_local_row = it.lr;
        i_local_col = it.lc;
        i_row_base = it.rb;
        i_col_base = it.cb;
        i_local_rows = it.lrows;
        i_block_start = it.bstart;
        i_h_value = it.h;
        i_s_value = it.s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        if (it.op == OP_LOAD) loaded[it.slot] = 1'b1;
        sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    // Lowers valid and waits until every awaited result has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [31:0] ly, logic [31:0] lz, logic [31:0] rbk,
                             logic [31:0] cbk, logic [31:0] gr, logic [31:0] gc,
                             logic [31:0] pr, logic [31:0] pc);
        drain();
        write_reg(CFG_CELL_LENGTH_Y, ly);
        write_reg(CFG_CELL_LENGTH_Z, lz);
        write_reg(CFG_ROW_BLOCK_SIZE, rbk);
        write_reg(CFG_COL_BLOCK_SIZE, cbk);
        write_reg(CFG_GRID_ROWS, gr);
        write_reg(CFG_GRID_COLS, gc);
        write_reg(CFG_MY_GRID_ROW, pr);
        write_reg(CFG_MY_GRID_COL, pc);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
        endcase
    endfunction

    function automatic elem_item_t load_item(logic [11:0] slot, logic [31:0] y,
                                             logic [31:0] z);
        elem_item_t it;
        it.op = OP_LOAD; it.slot = slot; it.y = y; it.z = z;
        it.lr = $urandom; it.lc = $urandom; it.rb = $urandom; it.cb = $urandom;
        it.lrows = $urandom; it.bstart = $urandom;
        it.h = {$urandom, $urandom}; it.s = {$urandom, $urandom};
        return it;
    endfunction

    // Sends a classify transfer, loading either orbital first if it is new.
    task automatic classify(logic [11:0] lr, logic [11:0] lc, logic [11:0] rb,
                            logic [11:0] cb, logic [12:0] lrows, logic [23:0] bs,
                            logic [63:0] h, logic [63:0] s);
        elem_item_t  it;
        logic [11:0] ro, co;
        ro = sb.row_orbital(lr, rb);
        co = sb.col_orbital(lc, cb);
        if (!loaded[ro]) send(load_item(ro, rand_coord(), rand_coord()));
        if (!loaded[co]) send(load_item(co, rand_coord(), rand_coord()));
        it = load_item(0, 0, 0);
        it.op = OP_CLASSIFY;
        it.lr = lr; it.lc = lc; it.rb = rb; it.cb = cb;
        it.lrows = lrows; it.bstart = bs; it.h = h; it.s = s;
        send(it);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send(load_item($urandom, rand_coord(), rand_coord()));
            else
                classify($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: coordinate extremes, index wrap, zero and full leading
        // dimension, address wrap, all-zero and all-one passed words.
        send(load_item(12'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        send(load_item(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send(load_item(12'd1, 32'h0, 32'h0));
        send(load_item(12'd2, 32'hFFFF_FFFF, 32'h0000_0001));
        classify(12'd0, 12'hFFF, 12'd0, 12'd0, 13'd0, 24'hFF_FFFF, '0, '1);
        classify(12'hFFF, 12'd0, 12'd1, 12'hFFF, 13'h1FFF, 24'hFF_FFFF, '1, '0);
        classify(12'd1, 12'd2, 12'd0, 12'd0, 13'd1, 24'd0, 64'h1, 64'h8000_0000_0000_0000);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        write_reg(4'd8, 32'hFFFF_FFFF);
        write_reg(4'd15, 32'h0);
        classify(12'd0, 12'hFFF, 12'd0, 12'd0, 13'd4096, 24'd0, '1, '1);
        classify(12'd2, 12'd1, 12'd0, 12'd0, 13'd7, 24'd3, '0, '0);
        configure(32'h0001_0000, 32'h0000_8000, 32'h1FF, 32'd256, 32'd256, 32'h1FF,
                  32'hFF, 32'hFF);
        classify(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 13'h1FFF, 24'hFF_FFFF, '1, '1);
        classify(12'd0, 12'd0, 12'd0, 12'd0, 13'd1, 24'd0, '0, '0);

        configure(32'h0010_0000, 32'h0020_0000, 1, 1, 1, 1, 0, 0);
        random_phase(110);
        configure($urandom, $urandom, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 511), $urandom, $urandom);
        hold_req = 1'b1;
        random_phase(110);
        drain();
        random_phase(50);
        configure(32'h7FFF_FFFF, 32'h0, 32'd256, 32'd1, 32'd1, 32'd256, 32'd0, 32'd255);
        random_phase(110);
        configure($urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                  $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                  $urandom_range(1, 8), $urandom_range(0, 7), $urandom_range(0, 7));
        random_phase(110);
        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        random_phase(50);
        calm = 1'b1;
        random_phase(60);

        drain();
        repeat (30) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[periodic_image_element_sorter_core.f]
hdl/pies_pkg.sv
hdl/pies_rem_step.sv
hdl/periodic_image_element_sorter_core.sv
hdl/pies_checker.sv
tb/periodic_image_element_sorter_core_tb.sv
